// ----- sv/lalpc_pkg.sv -----
// Shared types and constants for the linear actuator limit position controller.
package lalpc_pkg;

  localparam int unsigned POS_W    = 16;
  localparam int unsigned DUTY_W   = 16;
  localparam int unsigned VOLT_W   = 24;
  localparam int unsigned SUPPLY_W = 16;
  localparam int unsigned SCALE_W  = 7;   // set_voltage / supply stays below 100
  localparam int unsigned PROD_W   = DUTY_W + SCALE_W;
  localparam int unsigned DIV_W    = VOLT_W;
  localparam int unsigned DVS_W    = SUPPLY_W;
  localparam int unsigned CNT_W    = $clog2(DIV_W);

  // product / 100 as (product * ceil(2^30 / 100)) >> 30, exact for any product below 2^23
  localparam int unsigned RECIP_W     = 24;
  localparam int unsigned RPROD_W     = PROD_W + RECIP_W;
  localparam int unsigned RECIP_SHIFT = 30;
  localparam logic [RECIP_W-1:0] RECIP_MUL = RECIP_W'(10737419);

  localparam int unsigned APB_DW   = 32;
  localparam int unsigned APB_AW   = 4;

  localparam logic [PROD_W-1:0] PCT_DIVISOR = PROD_W'(100);
  localparam logic [PROD_W-1:0] ROUND_HALF  = PROD_W'(50);

  // register indexes
  localparam logic [1:0] REG_MAX_POSITION = 2'd0;
  localparam logic [1:0] REG_BASE_DUTY    = 2'd1;
  localparam logic [1:0] REG_SET_VOLTAGE  = 2'd2;

  localparam logic [POS_W-1:0]  RST_MAX_POSITION = POS_W'(4000);
  localparam logic [DUTY_W-1:0] RST_BASE_DUTY    = DUTY_W'(1000);
  localparam logic [VOLT_W-1:0] RST_SET_VOLTAGE  = VOLT_W'(240000);

  // item kinds and motion commands
  localparam logic       KIND_TICK    = 1'b0;
  localparam logic [1:0] CMD_RUN_DOWN = 2'd0;
  localparam logic [1:0] CMD_RUN_UP   = 2'd1;
  localparam logic [1:0] CMD_IDLE     = 2'd2;
  localparam logic [1:0] CMD_UNKNOWN  = 2'd3;

  // end stop latch
  localparam logic [1:0] LATCH_NONE   = 2'd0;
  localparam logic [1:0] LATCH_BOTTOM = 2'd1;
  localparam logic [1:0] LATCH_TOP    = 2'd2;

  // result status
  localparam logic [1:0] ST_RUNNING = 2'd0;
  localparam logic [1:0] ST_BOTTOM  = 2'd1;
  localparam logic [1:0] ST_TOP     = 2'd2;
  localparam logic [1:0] ST_IDLE    = 2'd3;

  typedef struct packed {
    logic capture;
    logic div_start;
    logic mul_load;
    logic recip_load;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_free;
  } ctrl_sts_t;

endpackage

// ----- sv/lalpc_chan_if.sv -----
// Request and result channel interfaces.
interface lalpc_in_if;
  import lalpc_pkg::*;
  logic                valid;
  logic                ready;
  logic                kind;
  logic [1:0]          command;
  logic                up_limit;
  logic                down_limit;
  logic                driver_fault;
  logic [SUPPLY_W-1:0] supply_voltage;

  modport source (output valid, kind, command, up_limit, down_limit, driver_fault,
                  supply_voltage, input ready);
  modport sink (input valid, kind, command, up_limit, down_limit, driver_fault,
                supply_voltage, output ready);
endinterface

interface lalpc_out_if;
  import lalpc_pkg::*;
  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] pwm_duty;
  logic              direction_down;
  logic              reset_pulse;
  logic [1:0]        status;
  logic [POS_W-1:0]  position_estimate;

  modport source (output valid, pwm_duty, direction_down, reset_pulse, status,
                  position_estimate, input ready);
  modport sink (input valid, pwm_duty, direction_down, reset_pulse, status,
                position_estimate, output ready);
endinterface

// ----- sv/lalpc_div.sv -----
// Serial restoring divider, one quotient bit per cycle.
module lalpc_div import lalpc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quot_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;

  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = diff[DVS_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DVS_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ----- sv/lalpc_datapath.sv -----
// Item registers, actuator state, supply compensation arithmetic and result register.
module lalpc_datapath import lalpc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctrl_cmd_t           cmd_i,
  output ctrl_sts_t           sts_o,
  input  logic [POS_W-1:0]    max_position_i,
  input  logic [DUTY_W-1:0]   base_duty_i,
  input  logic [VOLT_W-1:0]   set_voltage_i,
  input  logic                kind_i,
  input  logic [1:0]          command_i,
  input  logic                up_limit_i,
  input  logic                down_limit_i,
  input  logic                driver_fault_i,
  input  logic [SUPPLY_W-1:0] supply_voltage_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [DUTY_W-1:0]   pwm_duty_o,
  output logic                direction_down_o,
  output logic                reset_pulse_o,
  output logic [1:0]          status_o,
  output logic [POS_W-1:0]    position_estimate_o
);

  // captured request
  logic                kind_q;
  logic [1:0]          cmd_q;
  logic                up_q, dn_q, fault_q;
  logic [SUPPLY_W-1:0] supply_q;

  // actuator state
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [1:0]        latch_q, latch_d;
  logic [DUTY_W-1:0] duty_q, duty_d;
  logic              down_q, down_d;

  logic [PROD_W-1:0]  prod_q;
  logic [DUTY_W-1:0]  quot_q;
  logic [RPROD_W-1:0] recip_prod;
  logic [PROD_W-1:0]  pct_rem;

  logic              out_valid_q;
  logic [DUTY_W-1:0] o_duty_q;
  logic              o_down_q, o_pulse_q;
  logic [1:0]        o_status_q, status_d;
  logic [POS_W-1:0]  o_pos_q;
  logic              pulse_d;

  logic              div_done;
  logic [DIV_W-1:0]  div_quot;

  logic              power, drive;
  logic [VOLT_W-1:0] supply_x100;
  logic              bypass;
  logic [DUTY_W-1:0] rounded;
  logic [POS_W-1:0]  pos_sync;

  lalpc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (set_voltage_i),
    .divisor_i  (supply_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // supply <= set_voltage/100 is the same test as supply*100 <= set_voltage
  assign supply_x100 = VOLT_W'(supply_q) * VOLT_W'(100);
  assign bypass      = (supply_x100 <= set_voltage_i);

  assign recip_prod = RPROD_W'(prod_q) * RPROD_W'(RECIP_MUL);
  assign pct_rem    = prod_q - PROD_W'(quot_q) * PCT_DIVISOR;
  assign rounded    = quot_q + DUTY_W'(pct_rem > ROUND_HALF);

  always_comb begin
    power = 1'b0;
    if (kind_q != KIND_TICK) begin
      unique case (cmd_q)
        CMD_RUN_DOWN: power = !(dn_q || latch_q == LATCH_BOTTOM);
        CMD_RUN_UP:   power = !(up_q || latch_q == LATCH_TOP);
        CMD_IDLE,
        CMD_UNKNOWN:  power = 1'b0;
        default:      power = 1'b0;
      endcase
    end
  end

  assign drive = power && (base_duty_i != '0);

  always_comb begin
    pos_d    = pos_q;
    latch_d  = latch_q;
    duty_d   = duty_q;
    down_d   = down_q;
    status_d = ST_RUNNING;
    pulse_d  = 1'b0;
    pos_sync = dn_q ? '0 : (up_q ? max_position_i : pos_q);
    if (kind_q == KIND_TICK) begin
      pos_d = pos_sync;
      if (duty_q != '0) begin
        if (down_q) begin
          if (pos_sync != '0) pos_d = pos_sync - 1'b1;
        end else if (pos_sync < max_position_i) begin
          pos_d = pos_sync + 1'b1;
        end
      end
    end else begin
      unique case (cmd_q)
        CMD_RUN_DOWN: begin
          if (!power) begin
            latch_d  = LATCH_BOTTOM;
            pos_d    = '0;
            status_d = ST_BOTTOM;
          end else begin
            latch_d = LATCH_NONE;
            down_d  = 1'b1;
          end
        end
        CMD_RUN_UP: begin
          if (!power) begin
            latch_d  = LATCH_TOP;
            pos_d    = max_position_i;
            status_d = ST_TOP;
          end else begin
            latch_d = LATCH_NONE;
            down_d  = 1'b0;
          end
        end
        CMD_IDLE:    status_d = ST_IDLE;
        CMD_UNKNOWN: status_d = ST_RUNNING;
        default:     status_d = ST_RUNNING;
      endcase
      if (drive) begin
        pulse_d = fault_q;
        duty_d  = bypass ? base_duty_i : rounded;
      end else begin
        duty_d = '0;
      end
    end
  end

  assign sts_o.need_div = drive && !bypass;
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q   <= kind_i;
      cmd_q    <= command_i;
      up_q     <= up_limit_i;
      dn_q     <= down_limit_i;
      fault_q  <= driver_fault_i;
      supply_q <= supply_voltage_i;
    end
    if (cmd_i.mul_load) begin
      prod_q <= PROD_W'(base_duty_i) * PROD_W'(div_quot[SCALE_W-1:0]);
    end
    if (cmd_i.recip_load) begin
      quot_q <= recip_prod[RECIP_SHIFT +: DUTY_W];
    end
    if (cmd_i.commit) begin
      o_duty_q   <= duty_d;
      o_down_q   <= down_d;
      o_pulse_q  <= pulse_d;
      o_status_q <= status_d;
      o_pos_q    <= pos_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      latch_q     <= LATCH_NONE;
      duty_q      <= '0;
      down_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        pos_q   <= pos_d;
        latch_q <= latch_d;
        duty_q  <= duty_d;
        down_q  <= down_d;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o         = out_valid_q;
  assign pwm_duty_o          = o_duty_q;
  assign direction_down_o    = o_down_q;
  assign reset_pulse_o       = o_pulse_q;
  assign status_o            = o_status_q;
  assign position_estimate_o = o_pos_q;

endmodule

// ----- sv/lalpc_ctrl.sv -----
// Sequencer for request capture, supply compensation and result commit.
module lalpc_ctrl import lalpc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  ctrl_sts_t  sts_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EVAL  = 6'b000010,
    S_DIV   = 6'b000100,
    S_MUL   = 6'b001000,
    S_RECIP = 6'b010000,
    S_FIN   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.capture = in_valid_i;
        if (in_valid_i) state_d = S_EVAL;
      end
      S_EVAL: begin
        if (sts_i.need_div) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_load = 1'b1;
        state_d        = S_RECIP;
      end
      S_RECIP: begin
        cmd_o.recip_load = 1'b1;
        state_d          = S_FIN;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

// ----- sv/linear_actuator_limit_position_control.sv -----
// Top level: APB register file, sequencer and datapath of the actuator controller.
//
// Each request (10 ms tick or motion command) yields one result. Ticks, idle and
// unknown commands, blocked runs, runs with a zero base_duty and runs whose supply
// needs no compensation load the result register from S_EVAL, once the output
// register is free. A run with supply compensation goes through S_DIV, S_MUL,
// S_RECIP and S_FIN: S_EVAL starts a 24-step serial divider that gives
// set_voltage / supply_voltage, S_MUL multiplies by base_duty, S_RECIP divides
// the product by 100 with a reciprocal multiplication, and S_FIN rounds
// half down and loads the result. One request is in work at a time; the next one is
// taken while the previous result still waits in the output register, and its own
// result is held back until that one has gone. The user must write registers over APB
// only while no request is in work; the block itself does not enforce this.
module linear_actuator_limit_position_control import lalpc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  lalpc_in_if.sink          in_i,
  lalpc_out_if.source       out_o
);

  logic [POS_W-1:0]  max_position_q;
  logic [DUTY_W-1:0] base_duty_q;
  logic [VOLT_W-1:0] set_voltage_q;
  logic              wr_en;
  logic [1:0]        reg_idx;

  ctrl_cmd_t ctrl_cmd;
  ctrl_sts_t ctrl_sts;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_position_q <= RST_MAX_POSITION;
      base_duty_q    <= RST_BASE_DUTY;
      set_voltage_q  <= RST_SET_VOLTAGE;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MAX_POSITION: max_position_q <= pwdata[POS_W-1:0];
        REG_BASE_DUTY:    base_duty_q    <= pwdata[DUTY_W-1:0];
        REG_SET_VOLTAGE:  set_voltage_q  <= pwdata[VOLT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MAX_POSITION: prdata = APB_DW'(max_position_q);
      REG_BASE_DUTY:    prdata = APB_DW'(base_duty_q);
      REG_SET_VOLTAGE:  prdata = APB_DW'(set_voltage_q);
      default:          prdata = '0;
    endcase
  end

  lalpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (ctrl_sts),
    .cmd_o      (ctrl_cmd)
  );

  lalpc_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (ctrl_cmd),
    .sts_o               (ctrl_sts),
    .max_position_i      (max_position_q),
    .base_duty_i         (base_duty_q),
    .set_voltage_i       (set_voltage_q),
    .kind_i              (in_i.kind),
    .command_i           (in_i.command),
    .up_limit_i          (in_i.up_limit),
    .down_limit_i        (in_i.down_limit),
    .driver_fault_i      (in_i.driver_fault),
    .supply_voltage_i    (in_i.supply_voltage),
    .out_valid_o         (out_o.valid),
    .out_ready_i         (out_o.ready),
    .pwm_duty_o          (out_o.pwm_duty),
    .direction_down_o    (out_o.direction_down),
    .reset_pulse_o       (out_o.reset_pulse),
    .status_o            (out_o.status),
    .position_estimate_o (out_o.position_estimate)
  );

endmodule
